>>> rtl/lcpc_pkg.sv
// Shared types, constants and control structs for the lattice chain partition block.
// Depends on nothing; every other RTL file but lcpc_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package lcpc_pkg;

  // Sizing
  localparam int MAX_LATTICE_DEF = 64;
  localparam int MAX_LAYERS      = 4;
  localparam int FACTOR_INPUTS   = 4;
  localparam int LAYER_CAP       = (MAX_LAYERS < FACTOR_INPUTS) ? MAX_LAYERS : FACTOR_INPUTS;

  localparam int FAC_W  = 32;   // Q8.24 factor
  localparam int DENS_W = 48;   // Q16.32 density
  localparam int S_W    = 51;   // 4*d + d + d
  localparam int PHI_W  = S_W - 24 + FAC_W;
  localparam int PLO_W  = 24 + FAC_W;
  localparam int SUM_W  = 55;   // up to 64 densities (lattice size clamped to MAX_LATTICE_DEF)
  localparam int QUO_W  = 64;
  localparam int DVR_W  = 7;    // divisor up to 64
  localparam int LEN_W  = 7;    // lattice size up to 65 before the clamp
  localparam int CNT9_W = 9;    // compare width for counters vs sizes
  localparam int CFG_W  = 6;
  localparam int IDX_W  = 2;

  localparam int DIV_DIGIT_W = 8;
  localparam int DIV_CYCLES  = QUO_W / DIV_DIGIT_W;

  localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};
  localparam logic [DENS_W-1:0] ONE_Q32  = DENS_W'(64'h1_0000_0000);
  localparam logic [DVR_W-1:0]  DIV_SIX  = DVR_W'(6);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LATTICE_LAYERS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ADSORBING_LAYERS = 2'd1;
  localparam logic [IDX_W-1:0] REG_NEGLECT_DESORBED = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SMALL = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic [FAC_W-1:0] factor_layer0;
    logic [FAC_W-1:0] factor_layer1;
    logic [FAC_W-1:0] factor_layer2;
    logic [FAC_W-1:0] factor_layer3;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [DENS_W-1:0] kd;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_RD0, S_LD0, S_RDN, S_LDN, S_MULHI, S_MULLO,
    S_CDIV, S_CWAIT, S_CWR, S_FINISH, S_KDIV, S_KWAIT, S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic sat_clr;
    logic cnt_inc;
    logic seed_wr;
    logic rd_first;
    logic rd_next;
    logic ld_cur;
    logic ld_nxt;
    logic mul_hi;
    logic mul_lo;
    logic div_cell_go;
    logic div_kd_go;
    logic cell_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic too_small;
    logic seed_end;
    logic cell_end;
    logic ads_row;
    logic div_done;
    logic last;
    logic out_full;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/lcpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lcpc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lcpc_div.sv
// Multi-cycle unsigned divider, eight quotient bits per cycle, narrow divisor.
// Depends on lcpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcpc_div
  import lcpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [QUO_W-1:0] dividend,
  input  wire logic [DVR_W-1:0] divisor,
  output logic                  done,
  output logic      [QUO_W-1:0] quotient
);

  logic [QUO_W-1:0]                 work, work_next;
  logic [DVR_W-1:0]                 rem, rem_next;
  logic [DVR_W-1:0]                 dvr;
  logic [$clog2(DIV_CYCLES)-1:0]    cnt;
  logic                             busy;

  // one radix-256 digit: eight restoring steps on the narrow remainder
  always_comb begin
    logic [DVR_W-1:0]       r;
    logic [DVR_W:0]         t;
    logic [DIV_DIGIT_W-1:0] qd;
    r = rem;
    qd = '0;
    for (int b = DIV_DIGIT_W - 1; b >= 0; b--) begin
      t = {r, work[QUO_W - DIV_DIGIT_W + b]};
      if (t >= {1'b0, dvr}) begin
        t = t - {1'b0, dvr};
        qd[b] = 1'b1;
      end
      r = t[DVR_W-1:0];
    end
    rem_next  = r;
    work_next = {work[QUO_W-DIV_DIGIT_W-1:0], qd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == $clog2(DIV_CYCLES)'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvr  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient = work;

endmodule

`default_nettype wire

>>> rtl/lcpc_ctrl.sv
// Sequencer: seed sweep, per-cell step sweep, final division and result hand-off.
// Depends on lcpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcpc_ctrl
  import lcpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  ctrl_state_t state, state_next;
  logic        first, first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b1;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next = state;
    first_next = first;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (first)               state_next = S_SEED;
          else if (stat.too_small) state_next = S_FINISH;
          else                     state_next = S_RD0;
        end
      end
      S_SEED:  if (stat.seed_end) state_next = S_FINISH;
      S_RD0:   state_next = S_LD0;
      S_LD0:   state_next = S_RDN;
      S_RDN:   state_next = S_LDN;
      S_LDN:   state_next = stat.ads_row ? S_MULHI : S_CDIV;
      S_MULHI: state_next = S_MULLO;
      S_MULLO: state_next = S_CDIV;
      S_CDIV:  state_next = S_CWAIT;
      S_CWAIT: if (stat.div_done) state_next = S_CWR;
      S_CWR:   state_next = stat.cell_end ? S_FINISH : S_RDN;
      S_FINISH: begin
        first_next = stat.last;
        if (!stat.last)          state_next = S_IDLE;
        else if (stat.too_small) state_next = S_EMIT;
        else                     state_next = S_KDIV;
      end
      S_KDIV:  state_next = S_KWAIT;
      S_KWAIT: if (stat.div_done) state_next = S_EMIT;
      S_EMIT:  if (!stat.out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        cmd.sat_clr   = in_valid & first;
      end
      S_SEED: begin
        cmd.seed_wr = 1'b1;
        cmd.cnt_inc = ~stat.seed_end;
      end
      S_RD0:   cmd.rd_first    = 1'b1;
      S_LD0:   cmd.ld_cur      = 1'b1;
      S_RDN:   cmd.rd_next     = 1'b1;
      S_LDN:   cmd.ld_nxt      = 1'b1;
      S_MULHI: cmd.mul_hi      = 1'b1;
      S_MULLO: cmd.mul_lo      = 1'b1;
      S_CDIV:  cmd.div_cell_go = 1'b1;
      S_CWR: begin
        cmd.cell_wr = 1'b1;
        cmd.cnt_inc = ~stat.cell_end;
      end
      S_KDIV:  cmd.div_kd_go = 1'b1;
      S_EMIT:  cmd.out_load  = ~stat.out_full;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/lcpc_dp.sv
// Datapath: configuration, geometry, density memory, stencil, multiplier, divider, result.
// Depends on lcpc_pkg, lcpc_ram and lcpc_div.
`timescale 1ns / 1ps
`default_nettype none

module lcpc_dp
  import lcpc_pkg::*;
#(
  parameter int MAX_LATTICE = MAX_LATTICE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_item_t         in_data,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat
);

  localparam int AW = $clog2(MAX_LATTICE);

  // configuration
  logic [5:0] lattice_layers;
  logic [2:0] adsorbing_layers;
  logic       neglect_desorbed;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_layers   <= 6'd10;
      adsorbing_layers <= 3'd2;
      neglect_desorbed <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LATTICE_LAYERS:   lattice_layers   <= cfg_data;
        REG_ADSORBING_LAYERS: adsorbing_layers <= cfg_data[2:0];
        REG_NEGLECT_DESORBED: neglect_desorbed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // geometry
  logic [2:0]       ads, nlay;
  logic [LEN_W-1:0] len_raw, len, dvsr;
  logic             too_small;

  always_comb begin
    ads = adsorbing_layers;
    if (ads < 3'd1) ads = 3'd1;
    if (ads > 3'(LAYER_CAP)) ads = 3'(LAYER_CAP);
    nlay    = ads + {2'b0, neglect_desorbed};
    len_raw = {1'b0, lattice_layers} + {5'b0, neglect_desorbed, 1'b0};
    if (CNT9_W'(len_raw) > CNT9_W'(MAX_LATTICE)) len = LEN_W'(MAX_LATTICE);
    else                                          len = len_raw;
    if (neglect_desorbed) dvsr = (len >= LEN_W'(2)) ? len - LEN_W'(2) : '0;
    else                  dvsr = len;
    too_small = (len < {3'b0, nlay, 1'b0}) || (dvsr == '0);
  end

  // latched item and sweep counter
  in_item_t         item;
  logic [AW-1:0]    cnt;
  logic [CNT9_W-1:0] i9, len9, nlay9;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item)    cnt <= '0;
    else if (cmd.cnt_inc) cnt <= cnt + 1'b1;
  end

  assign i9    = CNT9_W'(cnt);
  assign len9  = CNT9_W'(len);
  assign nlay9 = CNT9_W'(nlay);

  // row classification and factor pick
  logic             ads_row, in_len, has_next;
  logic [2:0]       k;
  logic [FAC_W-1:0] fac;
  logic [FAC_W-1:0] fac_arr [FACTOR_INPUTS];

  assign fac_arr[0] = item.factor_layer0;
  assign fac_arr[1] = item.factor_layer1;
  assign fac_arr[2] = item.factor_layer2;
  assign fac_arr[3] = item.factor_layer3;

  always_comb begin
    in_len   = i9 < len9;
    has_next = (i9 + CNT9_W'(1)) < len9;
    ads_row  = in_len && ((i9 < nlay9) || (i9 + nlay9 >= len9));
    if (i9 < nlay9) k = 3'(cnt);
    else            k = 3'(len9 - CNT9_W'(1) - i9);
    fac = (k < ads) ? fac_arr[k[1:0]] : '0;
  end

  // density memory
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DENS_W-1:0] mem_wdata, mem_rdata, seed_val, cell_val;

  assign mem_we    = cmd.seed_wr | cmd.cell_wr;
  assign mem_re    = cmd.rd_first | cmd.rd_next;
  assign mem_raddr = cmd.rd_first ? '0 : AW'(i9 + CNT9_W'(1));
  assign seed_val  = (!too_small && ads_row) ? {8'b0, fac, 8'b0} : ONE_Q32;
  assign mem_wdata = cmd.seed_wr ? seed_val : cell_val;

  lcpc_ram #(.WIDTH(DENS_W), .DEPTH(MAX_LATTICE)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // stencil window and products
  logic [DENS_W-1:0] prv, cur, nxt, nxt_v;
  logic [S_W-1:0]    s;
  logic [PHI_W-1:0]  p_hi;
  logic [PLO_W-1:0]  p_lo;

  assign nxt_v = has_next ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.ld_cur) begin
      cur <= mem_rdata;
      prv <= '0;
    end
    if (cmd.ld_nxt) begin
      nxt <= nxt_v;
      s   <= (S_W'(cur) << 2) + S_W'(prv) + S_W'(nxt_v);
    end
    if (cmd.mul_hi) p_hi <= PHI_W'(s[S_W-1:24]) * PHI_W'(fac);
    if (cmd.mul_lo) p_lo <= PLO_W'(s[23:0]) * PLO_W'(fac);
    if (cmd.cell_wr) begin
      prv <= cur;
      cur <= nxt;
    end
  end

  // shared divider: cell rounding by six, then the final mean
  logic             div_go, div_done;
  logic [QUO_W-1:0] div_num, quo;
  logic [DVR_W-1:0] div_den;
  logic [SUM_W-1:0] sum;
  logic             quo_sat;

  assign div_go = cmd.div_cell_go | cmd.div_kd_go;

  always_comb begin
    if (cmd.div_kd_go) begin
      div_num = QUO_W'(sum) + QUO_W'(dvsr >> 1);
      div_den = dvsr;
    end else begin
      if (ads_row) div_num = QUO_W'(p_hi) + QUO_W'(p_lo >> 24) + QUO_W'(3);
      else         div_num = QUO_W'(s) + QUO_W'(3);
      div_den = DIV_SIX;
    end
  end

  lcpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_sat  = |quo[QUO_W-1:DENS_W];
  assign cell_val = quo_sat ? DENS_MAX : quo[DENS_W-1:0];

  // sum and saturation flag
  logic sat_seen;

  always_ff @(posedge clk) begin
    if (cmd.load_item)                    sum <= '0;
    else if (cmd.seed_wr && in_len)       sum <= sum + SUM_W'(seed_val);
    else if (cmd.cell_wr)                 sum <= sum + SUM_W'(cell_val);
  end

  always_ff @(posedge clk) begin
    if (rst)                                 sat_seen <= 1'b0;
    else if (cmd.sat_clr || cmd.out_load)    sat_seen <= 1'b0;
    else if (cmd.cell_wr && quo_sat)         sat_seen <= 1'b1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)                out_valid <= 1'b0;
    else if (cmd.out_load)  out_valid <= 1'b1;
    else if (out_ready)     out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (too_small) begin
        out_data.kd     <= '0;
        out_data.status <= STATUS_SMALL;
      end else begin
        out_data.kd     <= cell_val;
        out_data.status <= (sat_seen || quo_sat) ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign stat.too_small = too_small;
  assign stat.seed_end  = (i9 == CNT9_W'(MAX_LATTICE - 1));
  assign stat.cell_end  = (i9 + CNT9_W'(1)) == len9;
  assign stat.ads_row   = ads_row;
  assign stat.div_done  = div_done;
  assign stat.last      = item.last;
  assign stat.out_full  = out_valid & ~out_ready;

endmodule

`default_nettype wire

>>> rtl/lattice_chain_partition_coefficient.sv
// Top level of the lattice chain partition coefficient block.
// Depends on lcpc_pkg, lcpc_ctrl and lcpc_dp (which holds lcpc_ram and lcpc_div).
//
//  Channel  | Handshake            | Payload          | Moves
//  ---------+----------------------+------------------+------------------------------
//  in       | in_valid / in_ready  | in_data (4x Q8.24 factors, last) | one segment request
//  out      | out_valid/ out_ready | out_data (kd Q16.32, status)     | one result per chain
//  cfg      | cfg_we               | cfg_index, cfg_data              | register write, no wait
//
// Sequence: the first segment of a chain sweeps the whole density memory. A later
// segment steps through the sites of a lattice of size L one by one: each lattice
// site runs one memory read, two multiplies on factor rows, and a pass through the
// shared radix-256 divider. A last segment adds a division for the mean.
// Reset: rst is synchronous; it restores register defaults (10, 2, 0), marks the next
// segment as a chain start and drops any pending result. Density memory needs no clear.
// Stalls: a new request is taken while a result still waits in the output register;
// the block only holds before emitting the next result until that one is taken.
`timescale 1ns / 1ps
`default_nettype none

module lattice_chain_partition_coefficient
  import lcpc_pkg::*;
#(
  parameter int MAX_LATTICE = MAX_LATTICE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the chain-start flag and every step of the sweep
  lcpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // datapath: registers, density memory, stencil, multiplier, divider, result register
  lcpc_dp #(.MAX_LATTICE(MAX_LATTICE)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

>>> tb/tb_lattice_chain_partition_coefficient.sv
// Self-checking bench for lattice_chain_partition_coefficient: directed and random chains
// against a bit-exact density predictor kept in a small scoreboard class.
// Depends on lcpc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_lattice_chain_partition_coefficient;
  import lcpc_pkg::*;

  localparam int LATTICE_CAP = 64;
  localparam longint unsigned CYCLE_LIMIT = 12_000_000;
  // Margin for a worst-case later segment and the mean divide.
  localparam int SETTLE_CYCLES = 1500;

  // Predictor of the block plus the queue of results still owed by the RTL.
  class density_scoreboard;
    longint unsigned density[LATTICE_CAP];
    longint unsigned next_density[LATTICE_CAP];
    bit chain_start;
    bit sat_seen;
    logic [5:0] reg_lattice;
    logic [2:0] reg_adsorbing;
    logic       reg_neglect;
    out_item_t  owed[$];
    int         errors;

    function new();
      foreach (density[k]) density[k] = 0;
      chain_start   = 1;
      sat_seen      = 0;
      reg_lattice   = 6'd10;
      reg_adsorbing = 3'd2;
      reg_neglect   = 1'b0;
      errors        = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_LATTICE_LAYERS:   reg_lattice   = val[5:0];
        REG_ADSORBING_LAYERS: reg_adsorbing = val[2:0];
        REG_NEGLECT_DESORBED: reg_neglect   = val[0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the pore cannot hold the wall layers on both sides or the divisor is zero.
    function bit pore_shape(output int len, output int nlay, output int ads, output int dvs);
      int a;
      int l;
      a = reg_adsorbing;
      if (a < 1) a = 1;
      if (a > LAYER_CAP) a = LAYER_CAP;
      l = int'(reg_lattice) + 2 * int'(reg_neglect);
      if (l > LATTICE_CAP) l = LATTICE_CAP;
      ads  = a;
      nlay = a + int'(reg_neglect);
      len  = l;
      dvs  = reg_neglect ? ((l >= 2) ? l - 2 : 0) : l;
      return (l < 2 * nlay) || (dvs == 0);
    endfunction

    function longint unsigned wall_factor(in_item_t r, int k, int ads);
      if (k >= ads) return 0;
      case (k)
        0: return r.factor_layer0;
        1: return r.factor_layer1;
        2: return r.factor_layer2;
        3: return r.factor_layer3;
        default: return 0;
      endcase
    endfunction

    function longint unsigned clip48(longint unsigned v);
      if (v > longint'(DENS_MAX)) begin
        sat_seen = 1;
        return longint'(DENS_MAX);
      end
      return v;
    endfunction

    function void note_request(in_item_t r);
      int len, nlay, ads, dvs, k;
      bit tiny;
      longint unsigned s, f, q, total;
      out_item_t res;
      tiny = pore_shape(len, nlay, ads, dvs);
      if (chain_start) begin
        foreach (density[i]) density[i] = 64'h1_0000_0000;
        sat_seen = 0;
        if (!tiny) begin
          for (int j = 0; j < nlay; j++) begin
            f = wall_factor(r, j, ads) << 8;
            density[j] = f;
            density[len - 1 - j] = f;
          end
        end
        chain_start = 0;
      end else if (!tiny) begin
        for (int i = 0; i < len; i++) begin
          s = 4 * density[i];
          if (i > 0) s += density[i - 1];
          if (i + 1 < len) s += density[i + 1];
          if (i < nlay || i >= len - nlay) begin
            k = (i < nlay) ? i : len - 1 - i;
            f = wall_factor(r, k, ads);
            q = (s >> 24) * f + (((s & 64'hFF_FFFF) * f) >> 24);
            next_density[i] = clip48((q + 3) / 6);
          end else begin
            next_density[i] = clip48((s + 3) / 6);
          end
        end
        for (int i = 0; i < len; i++) density[i] = next_density[i];
      end
      if (!r.last) return;
      chain_start = 1;
      if (tiny) begin
        res.kd     = '0;
        res.status = STATUS_SMALL;
      end else begin
        total = 0;
        for (int i = 0; i < len; i++) total += density[i];
        res.kd     = DENS_W'(clip48((total + longint'(dvs / 2)) / longint'(dvs)));
        res.status = sat_seen ? STATUS_SAT : STATUS_OK;
      end
      sat_seen = 0;
      owed = {owed, res};
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result kd=%h status=%0d", got.kd, got.status));
        return;
      end
      want = owed.pop_front();
      if (got.kd !== want.kd)
        report($sformatf("kd got %h want %h", got.kd, want.kd));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
    endtask

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  density_scoreboard sb;
  longint unsigned   cycles = 0;
  int                hold_request;  // long receiver hold-off, in cycles
  bit                steady_mode;   // stretches with no idling on either side

  lattice_chain_partition_coefficient u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Drop the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lattice_chain_partition_coefficient NOT OK");
      $finish;
    end
  end

  // Check every accepted result at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Gap lengths: mostly short, now and then long.
  function automatic int pick_gap();
    if (steady_mode) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
    return $urandom_range(0, 3);
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        hold_request <= hold_request - 1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!steady_mode && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Offer one request after a gap and hold it until the block takes it.
  task automatic send_request(in_item_t r, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  // Lower valid, wait for every owed result, then let a trailing segment finish.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_pore(int lat, int ads, int neg);
    write_reg(REG_LATTICE_LAYERS, CFG_W'(lat));
    write_reg(REG_ADSORBING_LAYERS, CFG_W'(ads));
    write_reg(REG_NEGLECT_DESORBED, CFG_W'(neg));
  endtask

  // Factors fully random, between 0 and 2.0, or near 1.0 so that chains do not always saturate.
  function automatic logic [31:0] pick_factor();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'h0100_0000 + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2:       return $urandom_range(0, 32'h0200_0000);
      default: return 32'h0100_0000 + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  function automatic in_item_t make_segment(bit is_last);
    in_item_t r;
    r.factor_layer0 = pick_factor();
    r.factor_layer1 = pick_factor();
    r.factor_layer2 = pick_factor();
    r.factor_layer3 = pick_factor();
    r.last          = is_last;
    return r;
  endfunction

  function automatic in_item_t flat_segment(logic [31:0] f, bit is_last);
    in_item_t r;
    r.factor_layer0 = f;
    r.factor_layer1 = f;
    r.factor_layer2 = f;
    r.factor_layer3 = f;
    r.last          = is_last;
    return r;
  endfunction

  // One chain of n segments; only the final one carries the last bit.
  task automatic send_chain(int n);
    for (int i = 0; i < n; i++) send_request(make_segment(i == n - 1), pick_gap());
  endtask

  initial begin
    int sent;
    int lat;
    int chain_len;
    int budget;
    sb           = new();
    hold_request = 0;
    steady_mode  = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: default registers, single-segment chains at the factor extremes.
    send_request(flat_segment(32'h0000_0000, 1'b1), 0);
    send_request(flat_segment(32'hFFFF_FFFF, 1'b1), 0);
    // Two and three segment chains, one saturating.
    send_request(flat_segment(32'h0100_0000, 1'b0), 0);
    send_request(flat_segment(32'h0100_0000, 1'b1), 0);
    send_request(flat_segment(32'hFFFF_FFFF, 1'b0), 1);
    send_request(flat_segment(32'hFFFF_FFFF, 1'b0), 0);
    send_request(flat_segment(32'hFFFF_FFFF, 1'b1), 0);
    drain();
    // Zero adsorbing count clamps up, oversized count clamps down.
    set_pore(8, 0, 0);
    send_request(make_segment(1'b0), 0);
    send_request(make_segment(1'b1), 0);
    drain();
    set_pore(12, 7, 1);
    send_request(make_segment(1'b0), 0);
    send_request(make_segment(1'b1), 0);
    drain();
    // Pore too small, and a zero divisor in neglect mode.
    set_pore(1, 1, 0);
    send_request(make_segment(1'b0), 0);
    send_request(make_segment(1'b1), 0);
    drain();
    set_pore(0, 1, 1);
    send_request(make_segment(1'b1), 0);
    drain();
    // Widest pore with neglect overruns capacity and clamps.
    set_pore(63, 4, 1);
    send_request(make_segment(1'b0), 0);
    send_request(make_segment(1'b1), 0);
    drain();
    // Change the pore between segments of one chain; cells past the new size keep values.
    set_pore(20, 3, 0);
    send_request(make_segment(1'b0), 0);
    send_request(make_segment(1'b0), 0);
    drain();
    set_pore(9, 2, 1);
    send_request(make_segment(1'b0), 0);
    send_request(make_segment(1'b1), 0);
    drain();

    // Back pressure: hold the receiver while single-segment chains pile up.
    set_pore(4, 1, 0);
    hold_request = 3000;
    for (int i = 0; i < 12; i++) send_request(make_segment(1'b1), 0);
    drain();

    // Random phases: mostly small pores, now and then the widest ones.
    sent = 0;
    while (sent < 1900) begin
      if ($urandom_range(0, 9) == 0) begin
        lat    = $urandom_range(0, 1) ? 62 : 63;
        budget = 8;
      end else begin
        lat    = $urandom_range(0, 24) == 0 ? $urandom_range(0, 3) : $urandom_range(2, 14);
        budget = 80;
      end
      set_pore(lat, $urandom_range(0, 7), $urandom_range(0, 1));
      steady_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) hold_request = $urandom_range(200, 2500);
      for (int n = 0; n < budget; n += chain_len) begin
        chain_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 7);
        if ($urandom_range(0, 9) == 0) begin
          // Noise: a run of segments with a random last bit.
          for (int i = 0; i < chain_len; i++)
            send_request(make_segment($urandom_range(0, 2) == 0), pick_gap());
        end else begin
          send_chain(chain_len);
        end
      end
      // Close any open chain so the phase ends with nothing in flight.
      send_request(make_segment(1'b1), pick_gap());
      sent += budget + 1;
      steady_mode = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_lattice_chain_partition_coefficient OK");
    end else begin
      $display("tb_lattice_chain_partition_coefficient NOT OK");
    end
    $finish;
  end

endmodule
